/* sv/fsvc_pkg.sv */
package fsvc_pkg;

   // field widths
   localparam int unsigned SampleWidth = 32;
   localparam int unsigned CodeWidth   = 16;
   localparam int unsigned ProdWidth   = 42;
   localparam int unsigned MagWidth    = 20;

   // configuration port
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   // register indexes
   typedef enum logic [1:0] {
      REG_RANGE_MODE = 2'd0,
      REG_YCC_MODE   = 2'd1,
      REG_BIT_DEPTH  = 2'd2,
      REG_MAX_CODE   = 2'd3
   } csr_index_type;

   // range mode codes
   localparam logic [2:0] RANGE_FULL       = 3'd0;
   localparam logic [2:0] RANGE_STANDARD   = 3'd1;
   localparam logic [2:0] RANGE_RESTRICTED = 3'd2;
   localparam logic [2:0] RANGE_SDI_SCALED = 3'd3;
   localparam logic [2:0] RANGE_SDI        = 3'd4;

   // reset values
   localparam logic [2:0]  RESET_RANGE_MODE = RANGE_STANDARD;
   localparam logic        RESET_YCC_MODE   = 1'b1;
   localparam logic [4:0]  RESET_BIT_DEPTH  = 5'd10;
   localparam logic [15:0] RESET_MAX_CODE   = 16'd1023;

   // bit depth limits
   localparam logic [4:0] DEPTH_MIN = 5'd8;
   localparam logic [4:0] DEPTH_MAX = 5'd16;

   // float encoding
   localparam logic [7:0] EXP_SPECIAL = 8'hFF;
   localparam logic [8:0] EXP_BIAS_SHIFT = 9'd150;

   // nominal weights and offsets, times four, at depth eight
   localparam logic [17:0] W4_STD_LUMA   = 18'd876;   // 219 * 4
   localparam logic [17:0] W4_STD_CHROMA = 18'd896;   // 224 * 4
   localparam logic [17:0] O4_STD_LUMA   = 18'd64;    // 16 * 4
   localparam logic [17:0] O4_STD_CHROMA = 18'd512;   // 128 * 4
   localparam logic [17:0] W4_SDI_LUMA   = 18'd1015;  // 253.75 * 4
   localparam logic [17:0] W4_SDI_CHROMA = 18'd1012;  // 253.00 * 4

endpackage

/* sv/float_sample_to_video_code_top.sv */
// Video sample quantizer. Each req word carries an IEEE single-precision
// sample (tdata) and a chroma flag (tuser); the rsp word carries the 16-bit
// code, formed as floor(W*x + O + 1/2) with W and O picked from range_mode,
// ycc_mode, the chroma flag and bit_depth, clipped to 0..max_code and, in
// sdi scaled mode, shifted left by 16 - bit_depth. NaN gives 0; tlast is
// passed through. The datapath is four register stages (decode, 24x18
// multiply, exponent shift, offset and clip), which an accepted word passes in
// that order, and one word is taken per clock while rsp_tready is
// high; each stage holds its word independently under backpressure.
// Registers (APB, byte address 4*i): 0 range_mode, 1 ycc_mode,
// 2 bit_depth, 3 max_code. Change them only while the pipeline is empty.
module float_sample_to_video_code_top
   import fsvc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SampleWidth-1:0]  req_tdata,   // [31:0] sample_bits
   input  logic                    req_tuser,   // [0] is_chroma
   input  logic                    req_tlast,
   // result stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [CodeWidth-1:0]    rsp_tdata,   // [15:0] code_value
   output logic                    rsp_tlast,
   // configuration
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [CsrDataWidth-1:0] csr_pwdata,
   output logic [CsrDataWidth-1:0] csr_prdata,
   output logic                    csr_pready
);

   // configuration registers
   logic [2:0]  range_mode_ff;
   logic        ycc_mode_ff;
   logic [4:0]  bit_depth_ff;
   logic [15:0] max_code_ff;
   logic        csr_write;
   csr_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         range_mode_ff <= RESET_RANGE_MODE;
         ycc_mode_ff   <= RESET_YCC_MODE;
         bit_depth_ff  <= RESET_BIT_DEPTH;
         max_code_ff   <= RESET_MAX_CODE;
      end else if (csr_write) begin
         case (csr_index)
            REG_RANGE_MODE: range_mode_ff <= csr_pwdata[2:0];
            REG_YCC_MODE:   ycc_mode_ff   <= csr_pwdata[0];
            REG_BIT_DEPTH:  bit_depth_ff  <= csr_pwdata[4:0];
            REG_MAX_CODE:   max_code_ff   <= csr_pwdata[15:0];
            default:        ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_RANGE_MODE: csr_prdata = {29'd0, range_mode_ff};
         REG_YCC_MODE:   csr_prdata = {31'd0, ycc_mode_ff};
         REG_BIT_DEPTH:  csr_prdata = {27'd0, bit_depth_ff};
         REG_MAX_CODE:   csr_prdata = {16'd0, max_code_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // stage handshake: each stage loads when empty or when it moves on
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign rsp_tvalid = v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: weight and offset selection, float unpack
   logic [4:0]  bd;
   logic [3:0]  s;
   logic [2:0]  mode;
   logic        centered;
   logic [17:0] w4_in, o4_in;
   logic        shift_out_in;
   logic [3:0]  out_sh_in;
   logic [7:0]  ef;
   logic [22:0] ff;
   logic [7:0]  ef_adj;
   logic [23:0] mant_in;
   logic [8:0]  ex_in;
   logic        nan_in, inf_in;

   always_comb begin
      if (bit_depth_ff < DEPTH_MIN)      bd = DEPTH_MIN;
      else if (bit_depth_ff > DEPTH_MAX) bd = DEPTH_MAX;
      else                               bd = bit_depth_ff;
      s        = 4'(bd - DEPTH_MIN);
      centered = ycc_mode_ff && req_tuser;

      mode = range_mode_ff;
      if (mode > RANGE_SDI) mode = RANGE_STANDARD;
      if (bd == DEPTH_MIN && mode >= RANGE_RESTRICTED) mode = RANGE_STANDARD;

      shift_out_in = 1'b0;
      case (mode)
         RANGE_FULL: begin
            w4_in = ((18'd1 << bd) - 18'd1) << 2;
            o4_in = centered ? (18'd1 << (bd + 5'd1)) : 18'd0;
         end
         RANGE_RESTRICTED: begin
            w4_in = ((18'd1 << bd) - (18'd1 << (bd - 5'd7))) << 2;
            o4_in = centered ? (18'd1 << (bd + 5'd1)) : (18'd4 << s);
         end
         RANGE_SDI_SCALED, RANGE_SDI: begin
            w4_in = (centered ? W4_SDI_CHROMA : W4_SDI_LUMA) << s;
            o4_in = centered ? (18'd1 << (bd + 5'd1)) : (18'd4 << s);
            shift_out_in = (mode == RANGE_SDI_SCALED);
         end
         default: begin
            w4_in = (centered ? W4_STD_CHROMA : W4_STD_LUMA) << s;
            o4_in = (centered ? O4_STD_CHROMA : O4_STD_LUMA) << s;
         end
      endcase
      out_sh_in = 4'(DEPTH_MAX - bd);

      // denormals share the exponent of the smallest normal
      ef      = req_tdata[30:23];
      ff      = req_tdata[22:0];
      ef_adj  = (ef == 8'd0) ? 8'd1 : ef;
      mant_in = {(ef != 8'd0), ff};
      ex_in   = {1'b0, ef_adj} - EXP_BIAS_SHIFT;
      nan_in  = (ef == EXP_SPECIAL) && (ff != 23'd0);
      inf_in  = (ef == EXP_SPECIAL) && (ff == 23'd0);
   end

   logic [17:0] s1_w4_ff, s1_o4_ff;
   logic [23:0] s1_mant_ff;
   logic [8:0]  s1_ex_ff;
   logic        s1_neg_ff, s1_nan_ff, s1_inf_ff, s1_shift_out_ff, s1_last_ff;
   logic [3:0]  s1_out_sh_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_w4_ff        <= w4_in;
         s1_o4_ff        <= o4_in;
         s1_mant_ff      <= mant_in;
         s1_ex_ff        <= ex_in;
         s1_neg_ff       <= req_tdata[31];
         s1_nan_ff       <= nan_in;
         s1_inf_ff       <= inf_in;
         s1_shift_out_ff <= shift_out_in;
         s1_out_sh_ff    <= out_sh_in;
         s1_last_ff      <= req_tlast;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: mantissa times weight
   logic [ProdWidth-1:0] prod_in;
   assign prod_in = ProdWidth'(s1_mant_ff) * ProdWidth'(s1_w4_ff);

   logic [ProdWidth-1:0] s2_prod_ff;
   logic [17:0] s2_o4_ff;
   logic [8:0]  s2_ex_ff;
   logic        s2_neg_ff, s2_nan_ff, s2_inf_ff, s2_shift_out_ff, s2_last_ff;
   logic [3:0]  s2_out_sh_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_prod_ff      <= prod_in;
         s2_o4_ff        <= s1_o4_ff;
         s2_ex_ff        <= s1_ex_ff;
         s2_neg_ff       <= s1_neg_ff;
         s2_nan_ff       <= s1_nan_ff;
         s2_inf_ff       <= s1_inf_ff;
         s2_shift_out_ff <= s1_shift_out_ff;
         s2_out_sh_ff    <= s1_out_sh_ff;
         s2_last_ff      <= s1_last_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: scale by the exponent, floor magnitude with sticky bit
   logic [MagWidth-1:0]    q_in;
   logic                   frac_in, sat_in;
   logic [61:0]            wide;
   logic [ProdWidth-1:0]   rs, rmask;
   logic [8:0]             neg_ex;

   always_comb begin
      q_in    = '0;
      frac_in = 1'b0;
      sat_in  = 1'b0;
      wide    = '0;
      rs      = '0;
      rmask   = '0;
      neg_ex  = 9'd0 - s2_ex_ff;
      if (s2_inf_ff) begin
         sat_in = 1'b1;
      end else if (s2_prod_ff == '0) begin
         q_in = '0;
      end else if (!s2_ex_ff[8]) begin
         // left shift, large results saturate
         if (s2_ex_ff > 9'd20) begin
            sat_in = 1'b1;
         end else begin
            wide   = {20'd0, s2_prod_ff} << s2_ex_ff[4:0];
            sat_in = |wide[61:MagWidth];
            q_in   = wide[MagWidth-1:0];
         end
      end else if (neg_ex >= 9'(ProdWidth)) begin
         frac_in = 1'b1;
      end else begin
         rs      = s2_prod_ff >> neg_ex[5:0];
         rmask   = ~({ProdWidth{1'b1}} << neg_ex[5:0]);
         sat_in  = |rs[ProdWidth-1:MagWidth];
         q_in    = rs[MagWidth-1:0];
         frac_in = |(s2_prod_ff & rmask);
      end
   end

   logic [MagWidth-1:0] s3_q_ff;
   logic [17:0] s3_o4_ff;
   logic        s3_frac_ff, s3_sat_ff, s3_neg_ff, s3_nan_ff;
   logic        s3_shift_out_ff, s3_last_ff;
   logic [3:0]  s3_out_sh_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_q_ff         <= q_in;
         s3_frac_ff      <= frac_in;
         s3_sat_ff       <= sat_in;
         s3_o4_ff        <= s2_o4_ff;
         s3_neg_ff       <= s2_neg_ff;
         s3_nan_ff       <= s2_nan_ff;
         s3_shift_out_ff <= s2_shift_out_ff;
         s3_out_sh_ff    <= s2_out_sh_ff;
         s3_last_ff      <= s2_last_ff;
      end
   end

   // ---------------------------------------------------------------
   // stage 4: offset, round half up, clip, sdi shift
   logic signed [22:0] a_val, sum;
   logic [20:0]        c_raw;
   logic [15:0]        clipped, code_in;

   always_comb begin
      a_val = s3_neg_ff ? (23'sd0 - $signed({3'd0, s3_q_ff}) - $signed({22'd0, s3_frac_ff}))
                        : $signed({3'd0, s3_q_ff});
      sum   = a_val + $signed({5'd0, s3_o4_ff}) + 23'sd2;
      c_raw = sum[22] ? 21'd0 : sum[22:2];
      if (s3_sat_ff)
         clipped = s3_neg_ff ? 16'd0 : max_code_ff;
      else if (c_raw > {5'd0, max_code_ff})
         clipped = max_code_ff;
      else
         clipped = c_raw[15:0];
      code_in = s3_shift_out_ff ? (clipped << s3_out_sh_ff) : clipped;
      if (s3_nan_ff) code_in = 16'd0;
   end

   logic [CodeWidth-1:0] code_ff;
   logic                 last_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         code_ff <= code_in;
         last_ff <= s3_last_ff;
      end
   end

   assign rsp_tdata = code_ff;
   assign rsp_tlast = last_ff;

endmodule

/* sv/fsvc_checker.sv */
module fsvc_checker
   import fsvc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic [SampleWidth-1:0]  req_tdata,
   input logic                    req_tlast,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [CodeWidth-1:0]    rsp_tdata,
   input logic                    rsp_tlast
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed under backpressure");

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // with the output open, an accepted word comes out after passing every stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready)
      |=> rsp_tvalid)
      else $error("result word missing after four open cycles");

   // NaN gives a zero code
   a_nan_zero: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[30:23] == EXP_SPECIAL
       && req_tdata[22:0] != 23'd0 ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready)
      |=> rsp_tdata == 16'd0)
      else $error("NaN sample gave a nonzero code");

   // tlast follows its word
   a_last_pass: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready)
      |=> rsp_tlast == $past(req_tlast, 4))
      else $error("tlast does not match its word");

endmodule

bind float_sample_to_video_code_top fsvc_checker u_fsvc_checker (.*);

/* tb/float_sample_to_video_code_top_test.sv */
`timescale 1ns / 100ps

module float_sample_to_video_code_top_test;
   import fsvc_pkg::*;

   localparam int unsigned SpecialCount  = 22;
   localparam int unsigned DrainCycles   = 12;
   localparam int unsigned StallLimit    = 5000;
   localparam int unsigned SwapIdleAt    = 560;
   localparam int unsigned StopIdleAt    = 1120;
   localparam longint     MagnitudeCap  = 64'sd1 << 40;

   typedef struct packed {
      logic [31:0] bits;
      logic        chroma;
      logic        last;
   } sample_word_type;

   typedef struct packed {
      logic [15:0] code;
      logic        last;
   } code_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SampleWidth-1:0]  req_tdata = '0;   // [31:0] sample_bits
   logic                    req_tuser = 1'b0; // [0] is_chroma
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [CodeWidth-1:0]    rsp_tdata;        // [15:0] code_value
   logic                    rsp_tlast;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [CsrDataWidth-1:0] csr_pwdata = '0;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   // register copies used by the code predictor
   logic [2:0]  cfg_range = RESET_RANGE_MODE;
   logic        cfg_ycc   = RESET_YCC_MODE;
   logic [4:0]  cfg_depth = RESET_BIT_DEPTH;
   logic [15:0] cfg_max   = RESET_MAX_CODE;

   sample_word_type samples_pending [$];
   code_word_type   codes_due [$];
   code_word_type   code_head;
   logic         req_taken = 1'b0;
   int unsigned  words_in = 0;
   int unsigned  words_out = 0;
   int unsigned  error_count = 0;
   int unsigned  setting_count = 0;
   int unsigned  stall_cycles = 0;

   float_sample_to_video_code_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // expected code for one sample under the current register copies
   function automatic logic [15:0] video_code_of(input logic [31:0] bits, input logic chroma);
      int unsigned      depth;
      int unsigned      s;
      logic [2:0]       mode;
      bit               centered;
      bit               shift_out;
      bit               frac;
      bit               neg;
      longint unsigned  w4;
      longint unsigned  o4;
      longint unsigned  mant;
      longint unsigned  q;
      longint unsigned  c;
      longint           acc;
      longint           total;
      int               ex;
      int               k;
      logic [7:0]       ef;
      logic [22:0]      ff;
      depth = cfg_depth;
      if (depth < DEPTH_MIN) depth = DEPTH_MIN;
      if (depth > DEPTH_MAX) depth = DEPTH_MAX;
      s = depth - 8;
      mode = cfg_range;
      if (mode > RANGE_SDI) mode = RANGE_STANDARD;
      if (depth == DEPTH_MIN && mode >= RANGE_RESTRICTED) mode = RANGE_STANDARD;
      centered = cfg_ycc && chroma;
      shift_out = 1'b0;
      case (mode)
         RANGE_FULL: begin
            w4 = 4 * ((64'd1 << depth) - 64'd1);
            o4 = centered ? 4 * (64'd1 << (depth - 1)) : 64'd0;
         end
         RANGE_RESTRICTED: begin
            w4 = 4 * ((64'd1 << depth) - (64'd1 << (depth - 7)));
            o4 = 4 * (centered ? (64'd1 << (depth - 1)) : (64'd1 << s));
         end
         RANGE_SDI_SCALED, RANGE_SDI: begin
            w4 = 64'(centered ? W4_SDI_CHROMA : W4_SDI_LUMA) << s;
            o4 = 4 * (centered ? (64'd1 << (depth - 1)) : (64'd1 << s));
            shift_out = (mode == RANGE_SDI_SCALED);
         end
         default: begin
            w4 = 64'(centered ? W4_STD_CHROMA : W4_STD_LUMA) << s;
            o4 = 64'(centered ? O4_STD_CHROMA : O4_STD_LUMA) << s;
         end
      endcase
      ef = bits[30:23];
      ff = bits[22:0];
      neg = bits[31];
      if (ef == EXP_SPECIAL) begin
         // nan gives zero, infinities saturate
         if (ff != 0) return 16'd0;
         acc = neg ? -MagnitudeCap : MagnitudeCap;
      end else begin
         if (ef == 8'd0) begin
            mant = 64'(ff) * w4;
            ex = -149;
         end else begin
            mant = 64'({1'b1, ff}) * w4;
            ex = int'(ef) - 150;
         end
         // floor of the signed product, magnitude saturated
         q = 0;
         frac = 1'b0;
         if (mant != 0) begin
            if (ex >= 0) begin
               if (ex > 20) q = 64'(MagnitudeCap);
               else q = mant << ex;
               if (q > 64'(MagnitudeCap)) q = 64'(MagnitudeCap);
            end else begin
               k = -ex;
               if (k < 64) begin
                  q = mant >> k;
                  frac = (mant & ((64'd1 << k) - 64'd1)) != 0;
               end else begin
                  q = 0;
                  frac = 1'b1;
               end
            end
         end
         acc = longint'(q);
         if (neg) acc = -acc - (frac ? 64'sd1 : 64'sd0);
      end
      // round half up, clip, optional sdi shift
      total = acc + longint'(o4) + 64'sd2;
      if (total < 0) c = 0;
      else c = longint'(total) >>> 2;
      if (c > 64'(cfg_max)) c = 64'(cfg_max);
      if (shift_out) c = (c << (16 - depth)) & 64'hFFFF;
      return c[15:0];
   endfunction

   // corner-case sample patterns
   function automatic logic [31:0] special_sample(input int unsigned idx);
      case (idx)
         0:  return 32'h00000000;  // +0
         1:  return 32'h80000000;  // -0
         2:  return 32'h3F800000;  // 1.0
         3:  return 32'h3F000000;  // 0.5, rounding tie
         4:  return 32'hBF000000;  // -0.5
         5:  return 32'h7FC00000;  // quiet nan
         6:  return 32'h7F800001;  // signaling nan
         7:  return 32'hFFFFFFFF;  // negative nan, all ones
         8:  return 32'h7F800000;  // +inf
         9:  return 32'hFF800000;  // -inf
         10: return 32'h00000001;  // smallest denormal
         11: return 32'h80000001;  // negative denormal
         12: return 32'h807FFFFF;  // largest negative denormal
         13: return 32'h00800000;  // smallest normal
         14: return 32'h7F7FFFFF;  // largest finite
         15: return 32'hFF7FFFFF;  // most negative finite
         16: return 32'h3FC00000;  // 1.5, above range
         17: return 32'h60000000;  // huge finite
         18: return 32'h3E800000;  // 0.25
         19: return 32'hBD800000;  // -0.0625
         20: return 32'h3F7FFFFF;  // just under 1
         default: return 32'h7FFFFFFF;
      endcase
   endfunction

   // random sample, mostly inside the nominal video range
   function automatic sample_word_type random_sample();
      sample_word_type w;
      int unsigned  pick;
      logic [22:0]  frac;
      pick = $urandom_range(0, 99);
      frac = 23'($urandom);
      if (pick < 55) begin
         w.bits = {1'b0, 8'($urandom_range(112, 126)), frac};
      end else if (pick < 60) begin
         w.bits = {1'b0, 8'd127, 23'd0};
      end else if (pick < 70) begin
         w.bits = {1'b1, 8'($urandom_range(112, 125)), frac};
      end else if (pick < 80) begin
         // few mantissa bits so that halves land exactly
         w.bits = {1'($urandom), 8'($urandom_range(118, 127)), frac[22:19], 19'd0};
      end else if (pick < 85) begin
         w.bits = {1'b0, 8'd127, frac};
      end else if (pick < 90) begin
         w.bits = special_sample($urandom_range(0, SpecialCount - 1));
      end else begin
         w.bits = $urandom;
      end
      w.chroma = 1'($urandom);
      w.last = ($urandom_range(0, 7) == 0);
      return w;
   endfunction

   // one apb write followed by a read back of the same register
   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      logic [31:0] stored;
      case (idx)
         REG_RANGE_MODE: begin
            stored = value & 32'h7;
            cfg_range = stored[2:0];
         end
         REG_YCC_MODE: begin
            stored = value & 32'h1;
            cfg_ycc = stored[0];
         end
         REG_BIT_DEPTH: begin
            stored = value & 32'h1F;
            cfg_depth = stored[4:0];
         end
         default: begin
            stored = value & 32'hFFFF;
            cfg_max = stored[15:0];
         end
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrWidth'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== stored)
         $error("register %s: expected %h, actual %h", idx.name(), stored, csr_prdata);
      if (csr_prdata !== stored) error_count++;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // wait until every queued sample has produced its code
   task automatic wait_drained();
      while (samples_pending.size() != 0 || req_tvalid || codes_due.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [2:0] mode, input logic ycc,
                                input logic [4:0] depth, input logic [15:0] maxc);
      wait_drained();
      write_csr(REG_RANGE_MODE, 32'(mode));
      write_csr(REG_YCC_MODE, 32'(ycc));
      write_csr(REG_BIT_DEPTH, 32'(depth));
      write_csr(REG_MAX_CODE, 32'(maxc));
      setting_count++;
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) samples_pending.push_back(random_sample());
   endtask

   // stimulus sequence
   initial begin
      sample_word_type w;
      logic [4:0]   depth;
      int unsigned  eff;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corner samples under the reset settings
      for (int unsigned i = 0; i < SpecialCount; i++) begin
         w.bits = special_sample(i);
         w.chroma = i[0] ^ i[2];
         w.last = i[1];
         samples_pending.push_back(w);
      end

      // fixed settings, extremes and fallbacks
      apply_setting(RANGE_FULL, 1'b0, 5'd8, 16'd255);          queue_random(80);
      apply_setting(RANGE_FULL, 1'b1, 5'd16, 16'hFFFF);        queue_random(80);
      apply_setting(RANGE_STANDARD, 1'b1, 5'd8, 16'd255);      queue_random(80);
      apply_setting(RANGE_RESTRICTED, 1'b1, 5'd16, 16'hFFFF);  queue_random(80);
      apply_setting(RANGE_SDI_SCALED, 1'b0, 5'd12, 16'd4095);  queue_random(80);
      apply_setting(RANGE_SDI_SCALED, 1'b1, 5'd16, 16'hFFFF);  queue_random(80);
      apply_setting(RANGE_SDI, 1'b1, 5'd10, 16'd1023);         queue_random(80);
      apply_setting(RANGE_RESTRICTED, 1'b0, 5'd8, 16'd255);    queue_random(80);
      apply_setting(RANGE_SDI_SCALED, 1'b1, 5'd8, 16'd255);    queue_random(80);
      apply_setting(RANGE_STANDARD, 1'b0, 5'd0, 16'd255);      queue_random(80);
      apply_setting(RANGE_FULL, 1'b1, 5'd31, 16'hFFFF);        queue_random(80);
      apply_setting(3'd7, 1'b1, 5'd10, 16'd1023);              queue_random(80);
      apply_setting(RANGE_SDI_SCALED, 1'b1, 5'd10, 16'd0);     queue_random(80);
      apply_setting(RANGE_SDI_SCALED, 1'b0, 5'd10, 16'hFFFF);  queue_random(80);

      // random settings
      repeat (6) begin
         depth = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(8, 16));
         eff = (depth < 8) ? 8 : (depth > 16) ? 16 : depth;
         case ($urandom_range(0, 3))
            0: apply_setting(3'($urandom), 1'($urandom), depth, 16'($urandom));
            1: apply_setting(3'($urandom), 1'($urandom), depth, 16'hFFFF);
            default: apply_setting(3'($urandom), 1'($urandom), depth,
                                   16'((32'd1 << eff) - 1));
         endcase
         queue_random(85);
      end

      wait_drained();
      $display("%0d samples sent, %0d codes checked across %0d register settings",
               words_in, words_out, setting_count);
      $display("covered full, standard, restricted, sdi and sdi scaled ranges, depth 8 to 16");
      if (error_count == 0) begin
         $display("float_sample_to_video_code_top: match");
      end else begin
         $display("float_sample_to_video_code_top: mismatch");
      end
      $finish;
   end

   // request driver and result backpressure
   always @(negedge clock) begin
      int unsigned send_idle;
      int unsigned recv_idle;
      sample_word_type w;
      if (words_in < SwapIdleAt) begin
         send_idle = 24;
         recv_idle = 67;
      end else if (words_in < StopIdleAt) begin
         send_idle = 67;
         recv_idle = 24;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (samples_pending.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               w = samples_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= w.bits;
               req_tuser <= w.chroma;
               req_tlast <= w.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // monitor: predict on accept, compare on result
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            codes_due.push_back(code_word_type'{video_code_of(req_tdata, req_tuser),
                                                req_tlast});
            words_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            words_out++;
            if (codes_due.size() == 0) begin
               $error("code_value: expected none, actual %h", rsp_tdata);
               error_count++;
            end else begin
               code_head = codes_due.pop_front();
               if (rsp_tdata !== code_head.code) begin
                  $error("code_value: expected %h, actual %h", code_head.code, rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== code_head.last) begin
                  $error("last_out: expected %b, actual %b", code_head.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("float_sample_to_video_code_top: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

/* filelist.f */
sv/fsvc_pkg.sv
sv/float_sample_to_video_code_top.sv
sv/fsvc_checker.sv
tb/float_sample_to_video_code_top_test.sv
